// ----- hdl/named_multi_queue_mailbox_assert.svh -----
// Assertion macros for the mailbox RTL
`ifndef NAMED_MULTI_QUEUE_MAILBOX_ASSERT_SVH
`define NAMED_MULTI_QUEUE_MAILBOX_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define MQM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mailbox assertion failed");

// Check that cons holds in the cycle after ante
`define MQM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mailbox assertion failed");

`endif

// ----- hdl/mqm_pkg.sv -----
// ============================================================================
// mqm_pkg
// Shared types, constants and helper functions of the named queue mailbox.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mqm_pkg;

    localparam int unsigned QUEUE_COUNT_DEF   = 8;
    localparam int unsigned QUEUE_DEPTH_DEF   = 16;
    localparam int unsigned NAME_BYTES_DEF    = 8;
    localparam int unsigned MESSAGE_BYTES_DEF = 8;

    localparam int unsigned KIND_W          = 2;
    localparam int unsigned NAME_W          = 64;
    localparam int unsigned HANDLE_W        = 8;
    localparam int unsigned MSG_W           = 64;
    localparam int unsigned RESULT_HANDLE_W = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_OPEN    = 2'd0,
        KIND_SEND    = 2'd1,
        KIND_RECEIVE = 2'd2,
        KIND_POLL    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOOKUP,
        S_EXEC,
        S_MSG,
        S_RESP
    } t_state;

    // Keep name bytes up to the first zero byte, at most nbytes of them
    function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] raw,
                                                         input int unsigned nbytes);
        logic [NAME_W-1:0] kept;
        logic              stop;
        kept = '0;
        stop = 1'b0;
        for (int unsigned i = 0; i < NAME_W / 8; i++) begin
            if (i < nbytes && !stop) begin
                if (raw[8*i +: 8] == 8'd0) begin
                    stop = 1'b1;
                end else begin
                    kept[8*i +: 8] = raw[8*i +: 8];
                end
            end
        end
        return kept;
    endfunction

    // Mask of the low nbytes bytes of a message word
    function automatic logic [MSG_W-1:0] byte_mask(input int unsigned nbytes);
        logic [MSG_W-1:0] mask;
        mask = '0;
        for (int unsigned i = 0; i < MSG_W / 8; i++) begin
            if (i < nbytes) begin
                mask[8*i +: 8] = 8'hFF;
            end
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mqm_ifs.sv -----
// ============================================================================
// mqm_ifs
// Request and response channels of the mailbox, valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface mqm_req_if import mqm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [NAME_W-1:0]   queue_name;
    logic [HANDLE_W-1:0] queue_handle;
    logic [MSG_W-1:0]    message;

    modport source (output valid, output kind, output queue_name, output queue_handle,
                    output message, input ready);
    modport sink   (input valid, input kind, input queue_name, input queue_handle,
                    input message, output ready);
endinterface

interface mqm_rsp_if import mqm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [RESULT_HANDLE_W-1:0] result_handle;
    logic [MSG_W-1:0]           message_out;
    logic                       has_message;

    modport source (output valid, output status, output result_handle,
                    output message_out, output has_message, input ready);
    modport sink   (input valid, input status, input result_handle,
                    input message_out, input has_message, output ready);
endinterface

`default_nettype wire

// ----- hdl/mqm_name_table.sv -----
// ============================================================================
// mqm_name_table
// Queue name memory with registered read and the shared name comparator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mqm_name_table import mqm_pkg::*; #(
    parameter int unsigned QUEUE_COUNT = QUEUE_COUNT_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_wr_en,
    input  logic [((QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1)-1:0] i_wr_addr,
    input  logic [NAME_W-1:0]                                 i_wr_name,
    input  logic                                              i_rd_en,
    input  logic [((QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1)-1:0] i_rd_addr,
    input  logic [NAME_W-1:0]                                 i_cmp_name,
    output logic                                              o_match
);

    logic [NAME_W-1:0] r_mem [QUEUE_COUNT];
    logic [NAME_W-1:0] r_rd_name;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_name <= r_mem[i_rd_addr];
        end
    end

    assign o_match = (r_rd_name == i_cmp_name);

endmodule

`default_nettype wire

// ----- hdl/mqm_queue_store.sv -----
// ============================================================================
// mqm_queue_store
// Per-queue pointer/fill memory and the shared message ring memory.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mqm_queue_store import mqm_pkg::*; #(
    parameter int unsigned QUEUE_COUNT = QUEUE_COUNT_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_st_wr_en,
    input  logic [((QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1)-1:0] i_st_wr_addr,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]                    i_st_wr_wp,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]                    i_st_wr_rp,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]                  i_st_wr_fill,
    input  logic                                              i_st_rd_en,
    input  logic [((QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1)-1:0] i_st_rd_addr,
    output logic [$clog2(QUEUE_DEPTH)-1:0]                    o_st_wp,
    output logic [$clog2(QUEUE_DEPTH)-1:0]                    o_st_rp,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]                  o_st_fill,
    input  logic                                              i_msg_wr_en,
    input  logic                                              i_msg_rd_en,
    input  logic [((QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1)-1:0] i_msg_q,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]                    i_msg_ptr,
    input  logic [MSG_W-1:0]                                  i_msg_wr_data,
    output logic [MSG_W-1:0]                                  o_msg_rd_data
);

    localparam int unsigned PW     = $clog2(QUEUE_DEPTH);
    localparam int unsigned FW     = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned ST_W   = 2 * PW + FW;
    localparam int unsigned MSG_N  = QUEUE_COUNT * QUEUE_DEPTH;
    localparam int unsigned AW     = (MSG_N > 1) ? $clog2(MSG_N) : 1;

    logic [ST_W-1:0]  r_st_mem [QUEUE_COUNT];
    logic [ST_W-1:0]  r_st_rd;
    logic [MSG_W-1:0] r_msg_mem [MSG_N];
    logic [MSG_W-1:0] r_msg_rd;
    logic [AW-1:0]    msg_addr;

    assign msg_addr = AW'(i_msg_q) * AW'(QUEUE_DEPTH) + AW'(i_msg_ptr);

    always_ff @(posedge i_clk) begin
        if (i_st_wr_en) begin
            r_st_mem[i_st_wr_addr] <= {i_st_wr_wp, i_st_wr_rp, i_st_wr_fill};
        end
        if (i_st_rd_en) begin
            r_st_rd <= r_st_mem[i_st_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_msg_wr_en) begin
            r_msg_mem[msg_addr] <= i_msg_wr_data;
        end
        if (i_msg_rd_en) begin
            r_msg_rd <= r_msg_mem[msg_addr];
        end
    end

    assign o_st_wp       = r_st_rd[ST_W-1 -: PW];
    assign o_st_rp       = r_st_rd[FW +: PW];
    assign o_st_fill     = r_st_rd[FW-1:0];
    assign o_msg_rd_data = r_msg_rd;

endmodule

`default_nettype wire

// ----- hdl/named_multi_queue_mailbox.sv -----
// Open: the name scan reads one table entry per cycle through the shared comparator,
//   until a name matches or the last entry has been compared.
// Send and poll: handle lookup, then pointer memory read; receive adds a message read.
// One transaction in flight; the next is taken once the result sits in the output register.
// Reset clears the used flags, the sequencer and the output valid; no memory sweep.
// ============================================================================
// named_multi_queue_mailbox
// Table of named message queues with open, send, receive and poll.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "named_multi_queue_mailbox_assert.svh"

module named_multi_queue_mailbox import mqm_pkg::*; #(
    parameter int unsigned QUEUE_COUNT   = QUEUE_COUNT_DEF,
    parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int unsigned NAME_BYTES    = NAME_BYTES_DEF,
    parameter int unsigned MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mqm_req_if.sink   i_req,
    mqm_rsp_if.source o_rsp
);

    localparam int unsigned QIW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int unsigned CW  = QIW + 1;
    localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
    localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);

    t_state                     r_state, n_state;
    t_kind                      r_kind, n_kind;
    logic [NAME_W-1:0]          r_name, n_name;
    logic [HANDLE_W-1:0]        r_handle, n_handle;
    logic [MSG_W-1:0]           r_msg, n_msg;
    logic [QUEUE_COUNT-1:0]     r_used, n_used;
    logic [CW-1:0]              r_idx, n_idx;
    logic                       r_pend, n_pend;
    logic [QIW-1:0]             r_pidx, n_pidx;
    logic                       r_free_ok, n_free_ok;
    logic [QIW-1:0]             r_free_idx, n_free_idx;
    logic [QIW-1:0]             r_q, n_q;
    logic                       r_res_status, n_res_status;
    logic [RESULT_HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic [MSG_W-1:0]           r_res_msg, n_res_msg;
    logic                       r_res_has, n_res_has;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_status, n_out_status;
    logic [RESULT_HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [MSG_W-1:0]           r_out_msg, n_out_msg;
    logic                       r_out_has, n_out_has;

    logic                       accept;
    logic [QIW-1:0]             hidx;
    logic                       hvalid;

    logic                       nt_wr_en, nt_rd_en, nt_match;
    logic [QIW-1:0]             nt_wr_addr, nt_rd_addr;

    logic                       st_wr_en, st_rd_en;
    logic [QIW-1:0]             st_wr_addr;
    logic [PW-1:0]              st_wr_wp, st_wr_rp, st_wp, st_rp;
    logic [FW-1:0]              st_wr_fill, st_fill;
    logic                       msg_wr_en, msg_rd_en;
    logic [PW-1:0]              msg_ptr;
    logic [MSG_W-1:0]           msg_rd_data;

    mqm_name_table #(
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_name_table (
        .i_clk      (i_clk),
        .i_wr_en    (nt_wr_en),
        .i_wr_addr  (nt_wr_addr),
        .i_wr_name  (r_name),
        .i_rd_en    (nt_rd_en),
        .i_rd_addr  (nt_rd_addr),
        .i_cmp_name (r_name),
        .o_match    (nt_match)
    );

    mqm_queue_store #(
        .QUEUE_COUNT (QUEUE_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue_store (
        .i_clk         (i_clk),
        .i_st_wr_en    (st_wr_en),
        .i_st_wr_addr  (st_wr_addr),
        .i_st_wr_wp    (st_wr_wp),
        .i_st_wr_rp    (st_wr_rp),
        .i_st_wr_fill  (st_wr_fill),
        .i_st_rd_en    (st_rd_en),
        .i_st_rd_addr  (hidx),
        .o_st_wp       (st_wp),
        .o_st_rp       (st_rp),
        .o_st_fill     (st_fill),
        .i_msg_wr_en   (msg_wr_en),
        .i_msg_rd_en   (msg_rd_en),
        .i_msg_q       (r_q),
        .i_msg_ptr     (msg_ptr),
        .i_msg_wr_data (r_msg),
        .o_msg_rd_data (msg_rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign hidx   = QIW'(r_handle - HANDLE_W'(1));
    assign hvalid = (r_handle != '0) && (r_handle <= HANDLE_W'(QUEUE_COUNT)) && r_used[hidx];

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_name       = r_name;
        n_handle     = r_handle;
        n_msg        = r_msg;
        n_used       = r_used;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_free_ok    = r_free_ok;
        n_free_idx   = r_free_idx;
        n_q          = r_q;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_msg    = r_res_msg;
        n_res_has    = r_res_has;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;
        n_out_msg    = r_out_msg;
        n_out_has    = r_out_has;

        nt_wr_en   = 1'b0;
        nt_wr_addr = r_free_idx;
        nt_rd_en   = 1'b0;
        nt_rd_addr = r_idx[QIW-1:0];
        st_wr_en   = 1'b0;
        st_wr_addr = r_q;
        st_wr_wp   = st_wp;
        st_wr_rp   = st_rp;
        st_wr_fill = st_fill;
        st_rd_en   = 1'b0;
        msg_wr_en  = 1'b0;
        msg_rd_en  = 1'b0;
        msg_ptr    = st_wp;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind       = t_kind'(i_req.kind);
                    n_name       = normalize_name(i_req.queue_name, NAME_BYTES);
                    n_handle     = i_req.queue_handle;
                    n_msg        = i_req.message & byte_mask(MESSAGE_BYTES);
                    n_res_status = 1'b1;
                    n_res_handle = '0;
                    n_res_msg    = '0;
                    n_res_has    = 1'b0;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_free_ok    = 1'b0;
                    if (t_kind'(i_req.kind) == KIND_OPEN) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_LOOKUP;
                    end
                end
            end
            S_SCAN: begin
                if (r_name == '0) begin
                    n_state = S_RESP;
                end else begin
                    if (r_idx != CW'(QUEUE_COUNT)) begin
                        nt_rd_en = 1'b1;
                        n_idx    = r_idx + CW'(1);
                        n_pend   = 1'b1;
                        n_pidx   = r_idx[QIW-1:0];
                        if (!r_used[r_idx[QIW-1:0]] && !r_free_ok) begin
                            n_free_ok  = 1'b1;
                            n_free_idx = r_idx[QIW-1:0];
                        end
                    end else begin
                        n_pend = 1'b0;
                    end
                    if (r_pend) begin
                        if (r_used[r_pidx] && nt_match) begin
                            n_res_status = 1'b0;
                            n_res_handle = RESULT_HANDLE_W'({1'b0, r_pidx} + CW'(1));
                            n_state      = S_RESP;
                        end else if (r_pidx == QIW'(QUEUE_COUNT - 1)) begin
                            if (r_free_ok) begin
                                nt_wr_en             = 1'b1;
                                n_used[r_free_idx]   = 1'b1;
                                st_wr_en             = 1'b1;
                                st_wr_addr           = r_free_idx;
                                st_wr_wp             = '0;
                                st_wr_rp             = '0;
                                st_wr_fill           = '0;
                                n_res_status         = 1'b0;
                                n_res_handle = RESULT_HANDLE_W'({1'b0, r_free_idx} + CW'(1));
                            end
                            n_state = S_RESP;
                        end
                    end
                end
            end
            S_LOOKUP: begin
                if (hvalid) begin
                    st_rd_en = 1'b1;
                    n_q      = hidx;
                    n_state  = S_EXEC;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (r_kind)
                    KIND_POLL: begin
                        n_res_status = 1'b0;
                        n_res_has    = (st_fill != '0);
                    end
                    KIND_SEND: begin
                        if (st_fill != FW'(QUEUE_DEPTH)) begin
                            msg_wr_en    = 1'b1;
                            msg_ptr      = st_wp;
                            st_wr_en     = 1'b1;
                            st_wr_wp     = (st_wp == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                           : st_wp + PW'(1);
                            st_wr_fill   = st_fill + FW'(1);
                            n_res_status = 1'b0;
                        end
                    end
                    KIND_RECEIVE: begin
                        if (st_fill != '0) begin
                            msg_rd_en    = 1'b1;
                            msg_ptr      = st_rp;
                            st_wr_en     = 1'b1;
                            st_wr_rp     = (st_rp == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                           : st_rp + PW'(1);
                            st_wr_fill   = st_fill - FW'(1);
                            n_res_status = 1'b0;
                            n_state      = S_MSG;
                        end
                    end
                    default: begin
                        n_res_status = 1'b1;
                    end
                endcase
            end
            S_MSG: begin
                n_res_msg = msg_rd_data;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                    n_out_msg    = r_res_msg;
                    n_out_has    = r_res_has;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_free_ok   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_free_ok   <= n_free_ok;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_name       <= n_name;
        r_handle     <= n_handle;
        r_msg        <= n_msg;
        r_pidx       <= n_pidx;
        r_free_idx   <= n_free_idx;
        r_q          <= n_q;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_msg    <= n_res_msg;
        r_res_has    <= n_res_has;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
        r_out_msg    <= n_out_msg;
        r_out_has    <= n_out_has;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.result_handle = r_out_handle;
    assign o_rsp.message_out   = r_out_msg;
    assign o_rsp.has_message   = r_out_has;

    `MQM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `MQM_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, r_state == S_EXEC, st_fill <= FW'(QUEUE_DEPTH))
    `MQM_ASSERT_IMPL(a_handle_ok, i_clk, i_rst_n, r_out_valid && r_out_handle != '0, !r_out_status)
    `MQM_ASSERT_IMPL(a_has_ok, i_clk, i_rst_n, o_rsp.valid && o_rsp.has_message, !o_rsp.status)

endmodule

`default_nettype wire

// ----- verif/tb_named_multi_queue_mailbox.sv -----
// ============================================================================
// tb_named_multi_queue_mailbox
// Self-checking bench for the named queue mailbox. A scoreboard keeps its own
// queue table and predicts the reply to every accepted request. Directed
// corner cases run first, then random bursts of open, send, receive and poll
// with random idle gaps on both channels and long reply back-pressure stretches.
// ============================================================================
`timescale 1ns / 1ps

module tb_named_multi_queue_mailbox;
    import mqm_pkg::*;

    localparam int unsigned NQ        = QUEUE_COUNT_DEF;
    localparam int unsigned DEPTH     = QUEUE_DEPTH_DEF;
    localparam int unsigned POOL_SIZE = 12;
    localparam int unsigned ITEMS     = 1400;

    typedef struct packed {
        logic                       status;
        logic [RESULT_HANDLE_W-1:0] handle;
        logic [MSG_W-1:0]           word;
        logic                       has;
    } t_mailbox_reply;

    class mailbox_scoreboard;
        bit                  slot_open  [NQ];
        logic [NAME_W-1:0]   slot_name  [NQ];
        logic [MSG_W-1:0]    slot_ring  [NQ][DEPTH];
        int unsigned         slot_head  [NQ];
        int unsigned         slot_tail  [NQ];
        int unsigned         slot_level [NQ];
        t_mailbox_reply      awaited_replies[$];
        int unsigned         errors;

        function new();
            errors = 0;
            for (int i = 0; i < NQ; i++) begin
                slot_open[i]  = 1'b0;
                slot_head[i]  = 0;
                slot_tail[i]  = 0;
                slot_level[i] = 0;
            end
        endfunction

        function logic [NAME_W-1:0] trim_name(logic [NAME_W-1:0] raw);
            logic [NAME_W-1:0] kept;
            bit                ended;
            kept  = '0;
            ended = 1'b0;
            for (int b = 0; b < NAME_BYTES_DEF && b < 8; b++) begin
                if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
                if (!ended) kept[8*b +: 8] = raw[8*b +: 8];
            end
            return kept;
        endfunction

        function void note_request(t_kind kind, logic [NAME_W-1:0] name,
                                   logic [HANDLE_W-1:0] handle, logic [MSG_W-1:0] word);
            t_mailbox_reply    r;
            logic [NAME_W-1:0] key;
            logic [MSG_W-1:0]  keep_mask;
            int                idx;
            r        = '0;
            r.status = 1'b1;
            idx      = -1;
            if (handle != 0 && handle <= NQ && slot_open[int'(handle) - 1])
                idx = int'(handle) - 1;
            case (kind)
                KIND_OPEN: begin
                    key = trim_name(name);
                    if (key != '0) begin
                        for (int i = 0; i < NQ; i++)
                            if (r.handle == 0 && slot_open[i] && slot_name[i] == key)
                                r.handle = i + 1;
                        for (int i = 0; i < NQ; i++)
                            if (r.handle == 0 && !slot_open[i]) begin
                                slot_open[i]  = 1'b1;
                                slot_name[i]  = key;
                                slot_head[i]  = 0;
                                slot_tail[i]  = 0;
                                slot_level[i] = 0;
                                r.handle      = i + 1;
                            end
                    end
                    r.status = (r.handle == 0);
                end
                KIND_SEND: begin
                    if (idx >= 0 && slot_level[idx] < DEPTH) begin
                        keep_mask = '0;
                        for (int b = 0; b < MESSAGE_BYTES_DEF && b < 8; b++)
                            keep_mask[8*b +: 8] = 8'hFF;
                        slot_ring[idx][slot_head[idx]] = word & keep_mask;
                        slot_head[idx] = (slot_head[idx] + 1) % DEPTH;
                        slot_level[idx]++;
                        r.status = 1'b0;
                    end
                end
                KIND_RECEIVE: begin
                    if (idx >= 0 && slot_level[idx] > 0) begin
                        r.word = slot_ring[idx][slot_tail[idx]];
                        slot_tail[idx] = (slot_tail[idx] + 1) % DEPTH;
                        slot_level[idx]--;
                        r.status = 1'b0;
                    end
                end
                default: begin
                    if (idx >= 0) begin
                        r.status = 1'b0;
                        r.has    = (slot_level[idx] > 0);
                    end
                end
            endcase
            awaited_replies.push_back(r);
        endfunction

        function void compare_field(string label, logic [MSG_W-1:0] want,
                                    logic [MSG_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_mailbox_reply got);
            t_mailbox_reply want;
            if (awaited_replies.size() == 0) begin
                $display("%0t: reply with nothing awaited, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("result_handle", want.handle, got.handle);
            compare_field("message_out", want.word, got.word);
            compare_field("has_message", want.has, got.has);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mqm_req_if req_if ();
    mqm_rsp_if rsp_if ();

    named_multi_queue_mailbox u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    mailbox_scoreboard board = new();

    logic [NAME_W-1:0] name_pool [POOL_SIZE];
    int unsigned       name_len  [POOL_SIZE];
    int unsigned       issued = 0;
    bit                squeeze_pending = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_named_multi_queue_mailbox NOT OK");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
        return $urandom_range(1, NQ);
    endfunction

    // Fill the bytes past the name terminator with junk, on about half of the calls
    function automatic logic [NAME_W-1:0] dress_name(logic [NAME_W-1:0] base, int unsigned len);
        logic [NAME_W-1:0] w;
        w = base;
        if ($urandom_range(0, 1))
            for (int b = len + 1; b < 8; b++) w[8*b +: 8] = $urandom_range(0, 255);
        return w;
    endfunction

    task automatic issue(t_kind kind, logic [NAME_W-1:0] name,
                         logic [HANDLE_W-1:0] handle, logic [MSG_W-1:0] word);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= kind;
        req_if.queue_name   <= name;
        req_if.queue_handle <= handle;
        req_if.message      <= word;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        board.note_request(kind, name, handle, word);
        issued++;
    endtask

    task automatic random_burst();
        int unsigned mode;
        int unsigned len;
        int unsigned p;
        logic [HANDLE_W-1:0] h;
        mode = $urandom_range(0, 9);
        len  = $urandom_range(1, 24);
        h    = pick_handle();
        if ($urandom_range(0, 49) == 0) squeeze_pending = 1'b1;
        repeat (len) begin
            if ($urandom_range(0, 5) == 0) h = pick_handle();
            case (mode)
                0, 1, 2, 3: issue(KIND_SEND, {$urandom, $urandom}, h, {$urandom, $urandom});
                4, 5, 6:    issue(KIND_RECEIVE, {$urandom, $urandom}, h, {$urandom, $urandom});
                7:          issue(KIND_POLL, {$urandom, $urandom}, h, {$urandom, $urandom});
                8: begin
                    p = $urandom_range(0, POOL_SIZE - 1);
                    if ($urandom_range(0, 9) == 0)
                        issue(KIND_OPEN, {$urandom, $urandom} & ~64'hFF, h, '0);
                    else
                        issue(KIND_OPEN, dress_name(name_pool[p], name_len[p]), h,
                              {$urandom, $urandom});
                end
                default: issue(t_kind'($urandom_range(0, 3)), {$urandom, $urandom},
                               $urandom_range(0, 255), {$urandom, $urandom});
            endcase
        end
    endtask

    initial begin : response_pacing
        int unsigned low_run;
        int unsigned high_run;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (squeeze_pending) begin
                squeeze_pending = 1'b0;
                low_run = 200;
            end else begin
                low_run = pick_gap();
            end
            high_run = $urandom_range(1, 30);
            if (low_run != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (low_run) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat (high_run) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            board.check_reply('{rsp_if.status, rsp_if.result_handle,
                                rsp_if.message_out, rsp_if.has_message});
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.kind         <= KIND_OPEN;
        req_if.queue_name   <= '0;
        req_if.queue_handle <= '0;
        req_if.message      <= '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            name_len[i]  = (i % 8) + 1;
            name_pool[i] = '0;
            for (int b = 0; b < name_len[i]; b++) name_pool[i][8*b +: 8] = $urandom_range(1, 255);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unused entries, empty names, name matching, bad handles
        issue(KIND_POLL,    '0, 8'd1, '0);
        issue(KIND_SEND,    '0, 8'd1, 64'h1);
        issue(KIND_RECEIVE, '0, 8'd1, '0);
        issue(KIND_OPEN,    64'h0, 8'd0, '0);
        issue(KIND_OPEN,    64'hFFFF_FFFF_FFFF_FF00, 8'd0, '0);
        issue(KIND_OPEN,    64'hFFFF_FFFF_FFFF_FFFF, 8'd0, '0);
        issue(KIND_OPEN,    64'h0000_0000_0000_0041, 8'd0, '0);
        issue(KIND_OPEN,    64'hDEAD_BEEF_0000_0041, 8'd0, '0);
        issue(KIND_OPEN,    64'hFFFF_FFFF_FFFF_FFFF, 8'd0, '0);
        issue(KIND_SEND,    '0, 8'd0, 64'h5);
        issue(KIND_SEND,    '0, 8'd9, 64'h6);
        issue(KIND_SEND,    '0, 8'd255, 64'h7);
        issue(KIND_POLL,    '0, 8'd2, '0);
        issue(KIND_RECEIVE, '0, 8'd2, '0);
        issue(KIND_SEND,    '0, 8'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(KIND_SEND,    '0, 8'd2, 64'h0);
        issue(KIND_SEND,    '0, 8'd1, 64'h0123_4567_89AB_CDEF);
        issue(KIND_POLL,    '0, 8'd2, '0);
        issue(KIND_POLL,    '0, 8'd0, '0);
        issue(KIND_RECEIVE, '0, 8'd9, '0);
        issue(KIND_POLL,    '0, 8'd255, '0);
        issue(KIND_RECEIVE, '0, 8'd2, '0);
        issue(KIND_RECEIVE, '0, 8'd2, '0);
        issue(KIND_RECEIVE, '0, 8'd1, '0);

        squeeze_pending = 1'b1;
        while (issued < ITEMS) random_burst();
        req_if.valid <= 1'b0;

        while (board.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb_named_multi_queue_mailbox OK");
        end else begin
            $display("tb_named_multi_queue_mailbox NOT OK");
        end
        $finish;
    end

endmodule

// ----- named_multi_queue_mailbox.f -----
+incdir+hdl
hdl/mqm_pkg.sv
hdl/mqm_ifs.sv
hdl/mqm_name_table.sv
hdl/mqm_queue_store.sv
hdl/named_multi_queue_mailbox.sv
verif/tb_named_multi_queue_mailbox.sv
